### rtl/button_debounce_press_classifier_unit_assert.svh
// Assertion macros for the button debounce and press classifier.
// Both macros clock on clk_i and are disabled while rst_ni is low.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define BDPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("bdpc assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define BDPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("bdpc assertion failed");

`endif

### rtl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int BUTTON_COUNT = 9;

  localparam int CMD_W       = 2;
  localparam int PIN_W       = 9;
  localparam int SEL_W       = 4;
  localparam int CNT_W       = 16;
  localparam int ACT_W       = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int IN_FIELD_W  = CMD_W + PIN_W + SEL_W;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = ACT_W + PIN_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Commands; the fourth code does nothing.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Latched actions.
  localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SHORT     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LONG      = 2'd2;
  localparam logic [ACT_W-1:0] ACT_VERY_LONG = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_PRESS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL    = 2'd3;

  localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS  = 16'd50;
  localparam logic [CNT_W-1:0] RST_LONG_PRESS      = 16'd1000;
  localparam logic [CNT_W-1:0] RST_VERY_LONG_PRESS = 16'd3000;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] very_long_press_ticks;
    logic             pressed_level;
  } cfg_t;

  typedef struct packed {
    logic             advance;
    logic [CMD_W-1:0] command;
  } cell_ctl_t;

endpackage

### rtl/button_debounce_press_classifier_unit.sv
// Each result passes the input register, then the result register, before it is valid.
// Throughput: one item per cycle when not stalled; all buttons update in parallel in one pass.
// The input side stalls only while the result register is full and not taken.
// Reset (rst_ni low, asynchronous): every button starts, counters and actions clear,
// registers return to debounce 50, long 1000, very long 3000, pressed level 0.
`timescale 1ns / 1ps

module button_debounce_press_classifier_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command[1:0], pin_levels[10:2], button_select[14:11], zero pad
  input  logic [bdpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // selected_action[1:0], debounced_pressed[10:2], zero pad
  output logic [bdpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bdpc_pkg::CFG_W-1:0]          cfg_data_i
);
  import bdpc_pkg::*;

  localparam int EXT_W = (BUTTON_COUNT > PIN_W) ? BUTTON_COUNT : PIN_W;

  cfg_t cfg_q;

  logic             in_valid_q;
  logic [CMD_W-1:0] cmd_q;
  logic [PIN_W-1:0] pins_q;
  logic [SEL_W-1:0] sel_q;

  logic             out_valid_q;
  logic [ACT_W-1:0] action_q;
  logic [PIN_W-1:0] pressed_q;

  logic s_accept, out_ready, advance;

  cell_ctl_t               cell_ctl;
  logic [EXT_W-1:0]        pins_ext, pressed_ext;
  logic [BUTTON_COUNT-1:0] levels, pressed_d;
  logic [ACT_W-1:0]        action_d [BUTTON_COUNT];
  logic [ACT_W-1:0]        sel_action;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks        <= RST_DEBOUNCE_TICKS;
      cfg_q.long_press_ticks      <= RST_LONG_PRESS;
      cfg_q.very_long_press_ticks <= RST_VERY_LONG_PRESS;
      cfg_q.pressed_level         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_TICKS:  cfg_q.debounce_ticks        <= CNT_W'(cfg_data_i);
        REG_LONG_PRESS:      cfg_q.long_press_ticks      <= CNT_W'(cfg_data_i);
        REG_VERY_LONG_PRESS: cfg_q.very_long_press_ticks <= CNT_W'(cfg_data_i);
        REG_PRESSED_LEVEL:   cfg_q.pressed_level         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // advance a held input when the result register is empty or its transfer completes now
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= s_axis_tdata[CMD_W-1:0];
      pins_q <= s_axis_tdata[CMD_W+PIN_W-1:CMD_W];
      sel_q  <= s_axis_tdata[IN_FIELD_W-1:CMD_W+PIN_W];
    end
  end

  // buttons beyond the pin field see level zero
  assign pins_ext = EXT_W'(pins_q);
  assign levels   = pins_ext[BUTTON_COUNT-1:0];
  assign cell_ctl = '{advance: advance, command: cmd_q};

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_cell
    bdpc_button u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .cfg_i       (cfg_q),
      .level_i     (levels[b]),
      .action_d_o  (action_d[b]),
      .pressed_d_o (pressed_d[b])
    );
  end

  // out-of-range select reports no action
  always_comb begin
    sel_action = ACT_NONE;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (int'(sel_q) == b) sel_action = action_d[b];
    end
  end

  assign pressed_ext = EXT_W'(pressed_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      action_q  <= sel_action;
      pressed_q <= pressed_ext[PIN_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({pressed_q, action_q});

endmodule

### rtl/bdpc_button.sv
`timescale 1ns / 1ps

module bdpc_button (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdpc_pkg::cell_ctl_t       ctl_i,
  input  bdpc_pkg::cfg_t            cfg_i,
  input  logic                      level_i,
  output logic [bdpc_pkg::ACT_W-1:0] action_d_o,
  output logic                      pressed_d_o
);
  import bdpc_pkg::*;

  typedef enum logic [1:0] {
    PH_START,
    PH_RELEASED,
    PH_DEBOUNCE,
    PH_PRESSED
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] hold_q, hold_d;
  logic             await_q, await_d;
  logic [ACT_W-1:0] action_q, action_d;
  logic             down;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    hold_d   = hold_q;
    await_d  = await_q;
    action_d = action_q;
    down     = (level_i == cfg_i.pressed_level);

    unique case (ctl_i.command)
      CMD_TICK: begin
        if (count_q < cfg_i.debounce_ticks) begin
          count_d = count_q + 1'b1;
        end
        if (await_q) begin
          // saturate instead of wrapping
          if (hold_q != '1) begin
            hold_d = hold_q + 1'b1;
          end
        end else begin
          hold_d = '0;
        end
      end
      CMD_SAMPLE: begin
        unique case (phase_q)
          PH_START: begin
            if (!down) phase_d = PH_RELEASED;
          end
          PH_RELEASED: begin
            if (down) begin
              phase_d = PH_DEBOUNCE;
              count_d = '0;
            end
          end
          PH_DEBOUNCE: begin
            if (count_q >= cfg_i.debounce_ticks) begin
              phase_d = down ? PH_PRESSED : PH_RELEASED;
            end
          end
          PH_PRESSED: begin
            if (!down) begin
              phase_d = PH_DEBOUNCE;
              count_d = '0;
            end
          end
          default: ;
        endcase
        // classify on the new phase, only while no action is pending
        if (action_q == ACT_NONE) begin
          if (!await_q) begin
            if (phase_d == PH_PRESSED) await_d = 1'b1;
          end else if (phase_d == PH_RELEASED) begin
            await_d = 1'b0;
            if (hold_q >= cfg_i.very_long_press_ticks) begin
              action_d = ACT_VERY_LONG;
            end else if (hold_q >= cfg_i.long_press_ticks) begin
              action_d = ACT_LONG;
            end else begin
              action_d = ACT_SHORT;
            end
          end
        end
      end
      CMD_CLEAR: begin
        action_d = ACT_NONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      count_q  <= '0;
      hold_q   <= '0;
      await_q  <= 1'b0;
      action_q <= ACT_NONE;
    end else if (ctl_i.advance) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      hold_q   <= hold_d;
      await_q  <= await_d;
      action_q <= action_d;
    end
  end

  assign action_d_o  = action_d;
  assign pressed_d_o = (phase_d == PH_PRESSED);

endmodule

### rtl/bdpc_checker.sv
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_unit_assert.svh"

module bdpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bdpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bdpc_pkg::*;

  // a stalled result holds its value
  `BDPC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // the input side stalls only behind a stalled result
  `BDPC_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // every input transfer is followed, after the input register, by a valid result
  `BDPC_ASSERT_IMP(a_result_follows, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid)

  // bits above the result fields stay zero
  `BDPC_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0)

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bdpc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int GAP_MAX         = 15;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 4;

  typedef enum logic [1:0] {
    PH_STARTING,
    PH_RELEASED,
    PH_DEBOUNCING,
    PH_PRESSED
  } phase_e;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [PIN_W-1:0] pins;
    logic [CMD_W-1:0] cmd;
  } button_cmd_t;

  typedef struct packed {
    logic [PIN_W-1:0] pressed;
    logic [ACT_W-1:0] action;
  } press_report_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // command[1:0], pin_levels[10:2], button_select[14:11], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // selected_action[1:0], debounced_pressed[10:2], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  button_debounce_press_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of configuration and per-button state.
  logic [CNT_W-1:0] cfg_debounce;
  logic [CNT_W-1:0] cfg_long;
  logic [CNT_W-1:0] cfg_very_long;
  logic             cfg_level;

  phase_e           btn_phase  [BUTTON_COUNT];
  logic [CNT_W-1:0] db_count   [BUTTON_COUNT];
  logic             awaiting   [BUTTON_COUNT];
  logic [CNT_W-1:0] hold_ticks [BUTTON_COUNT];
  logic [ACT_W-1:0] latched    [BUTTON_COUNT];

  button_cmd_t   button_cmds_q [$];
  press_report_t expected_reports [$];

  logic in_xfer       = 1'b0;
  logic out_xfer      = 1'b0;
  bit   send_idle_en  = 1'b1;
  bit   recv_idle_en  = 1'b1;
  bit   hold_off_req  = 1'b0;
  bit   hold_off      = 1'b0;
  int   send_gap      = 0;
  int   recv_wait     = 0;
  int   mismatch_count = 0;

  function automatic int draw_wait(input bit enabled);
    return enabled ? $urandom_range(0, GAP_MAX) : 0;
  endfunction

  function automatic press_report_t next_press_report(input button_cmd_t c);
    press_report_t r;
    logic          down;
    case (c.cmd)
      CMD_TICK: begin
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          if (db_count[b] < cfg_debounce) db_count[b] = db_count[b] + 1'b1;
          if (awaiting[b]) begin
            // saturate instead of wrapping
            if (hold_ticks[b] != {CNT_W{1'b1}}) hold_ticks[b] = hold_ticks[b] + 1'b1;
          end else begin
            hold_ticks[b] = '0;
          end
        end
      end
      CMD_SAMPLE: begin
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          down = (b < PIN_W) ? (c.pins[b] == cfg_level) : (cfg_level == 1'b0);
          case (btn_phase[b])
            PH_STARTING: begin
              if (!down) btn_phase[b] = PH_RELEASED;
            end
            PH_RELEASED: begin
              if (down) begin
                btn_phase[b] = PH_DEBOUNCING;
                db_count[b]  = '0;
              end
            end
            PH_DEBOUNCING: begin
              if (db_count[b] >= cfg_debounce) btn_phase[b] = down ? PH_PRESSED : PH_RELEASED;
            end
            default: begin
              if (!down) begin
                btn_phase[b] = PH_DEBOUNCING;
                db_count[b]  = '0;
              end
            end
          endcase
        end
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          if (latched[b] == ACT_NONE) begin
            if (!awaiting[b]) begin
              if (btn_phase[b] == PH_PRESSED) awaiting[b] = 1'b1;
            end else if (btn_phase[b] == PH_RELEASED) begin
              awaiting[b] = 1'b0;
              if (hold_ticks[b] >= cfg_very_long)  latched[b] = ACT_VERY_LONG;
              else if (hold_ticks[b] >= cfg_long)  latched[b] = ACT_LONG;
              else                                 latched[b] = ACT_SHORT;
            end
          end
        end
      end
      CMD_CLEAR: begin
        for (int b = 0; b < BUTTON_COUNT; b++) latched[b] = ACT_NONE;
      end
      default: ;
    endcase
    r.pressed = '0;
    for (int b = 0; b < BUTTON_COUNT && b < PIN_W; b++)
      r.pressed[b] = (btn_phase[b] == PH_PRESSED);
    r.action = (c.sel < BUTTON_COUNT) ? latched[c.sel] : ACT_NONE;
    return r;
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin : monitor
    press_report_t got;
    press_report_t want;
    in_xfer  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_xfer <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(next_press_report(s_axis_tdata[$bits(button_cmd_t)-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_FIELD_W-1:0];
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: action %0d pressed %h", got.action, got.pressed);
        end else begin
          want = expected_reports.pop_front();
          if (got.action !== want.action || got.pressed !== want.pressed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: action exp %0d got %0d, pressed exp %h got %h",
                       want.action, got.action, want.pressed, got.pressed);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : feeder
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_xfer) send_gap = draw_wait(send_idle_en);
      if (!s_axis_tvalid || in_xfer) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (button_cmds_q.size() > 0) begin
          s_axis_tdata  <= {{(IN_TDATA_W-$bits(button_cmd_t)){1'b0}}, button_cmds_q.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_xfer) recv_wait = draw_wait(recv_idle_en);
      if (hold_off || recv_wait > 0) begin
        if (recv_wait > 0) recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin : receiver_hold_off
    wait (hold_off_req);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [PIN_W-1:0] pins,
                           input logic [SEL_W-1:0] sel);
    button_cmd_t c;
    c.cmd  = cmd;
    c.pins = pins;
    c.sel  = sel;
    button_cmds_q.push_back(c);
  endtask

  task automatic drain();
    while (button_cmds_q.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_DEBOUNCE_TICKS:  cfg_debounce  = val;
      REG_LONG_PRESS:      cfg_long      = val;
      REG_VERY_LONG_PRESS: cfg_very_long = val;
      REG_PRESSED_LEVEL:   cfg_level     = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] lng,
                            input logic [CNT_W-1:0] vlng, input logic lvl);
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_VERY_LONG_PRESS, vlng);
    write_reg(REG_PRESSED_LEVEL, {{(CFG_W-1){1'b0}}, lvl});
  endtask

  // Mostly held buttons that toggle now and then, with bounce and noise mixed in.
  task automatic queue_sessions(input int count);
    logic [PIN_W-1:0] held;
    logic [PIN_W-1:0] pins;
    logic [SEL_W-1:0] sel;
    int               roll;
    int               idx;
    held = '0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        idx = $urandom_range(0, PIN_W-1);
        held[idx] = ~held[idx];
      end
      pins = cfg_level ? held : ~held;
      sel  = ($urandom_range(0, 9) == 0) ? SEL_W'($urandom_range(BUTTON_COUNT, 15))
                                         : SEL_W'($urandom_range(0, BUTTON_COUNT-1));
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        queue_cmd(CMD_TICK, PIN_W'($urandom_range(0, 511)), sel);
      end else if (roll < 85) begin
        if ($urandom_range(0, 9) == 0) pins ^= PIN_W'($urandom_range(0, 511));
        queue_cmd(CMD_SAMPLE, pins, sel);
      end else if (roll < 90) begin
        queue_cmd(CMD_CLEAR, PIN_W'($urandom_range(0, 511)), sel);
      end else if (roll < 94) begin
        queue_cmd(CMD_NOP, PIN_W'($urandom_range(0, 511)), sel);
      end else begin
        queue_cmd(CMD_SAMPLE, PIN_W'($urandom_range(0, 511)), sel);
      end
    end
  endtask

  initial begin : sequencer
    int n;
    cfg_debounce  = RST_DEBOUNCE_TICKS;
    cfg_long      = RST_LONG_PRESS;
    cfg_very_long = RST_VERY_LONG_PRESS;
    cfg_level     = 1'b0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      btn_phase[b]  = PH_STARTING;
      db_count[b]   = '0;
      awaiting[b]   = 1'b0;
      hold_ticks[b] = '0;
      latched[b]    = ACT_NONE;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: unused command, leave starting, start debouncing.
    queue_cmd(CMD_NOP, 9'h155, 4'd15);
    queue_cmd(CMD_SAMPLE, 9'h1FF, 4'd0);
    queue_cmd(CMD_SAMPLE, 9'h000, 4'd9);
    queue_cmd(CMD_TICK, 9'h0AA, 4'd8);
    queue_cmd(CMD_CLEAR, 9'h000, 4'd0);
    drain();

    // Active-high pins, zero debounce: short, long and very long releases.
    set_config(16'd0, 16'd2, 16'd4, 1'b1);
    queue_cmd(CMD_SAMPLE, 9'h1FF, 4'd0);
    queue_cmd(CMD_TICK, 9'h000, 4'd0);
    queue_cmd(CMD_SAMPLE, 9'h1FE, 4'd0);
    queue_cmd(CMD_SAMPLE, 9'h1FE, 4'd0);
    queue_cmd(CMD_TICK, 9'h000, 4'd0);
    queue_cmd(CMD_TICK, 9'h000, 4'd1);
    queue_cmd(CMD_SAMPLE, 9'h1FC, 4'd1);
    queue_cmd(CMD_SAMPLE, 9'h1FC, 4'd1);
    queue_cmd(CMD_TICK, 9'h000, 4'd2);
    queue_cmd(CMD_TICK, 9'h000, 4'd2);
    queue_cmd(CMD_SAMPLE, 9'h000, 4'd2);
    queue_cmd(CMD_SAMPLE, 9'h000, 4'd8);
    queue_cmd(CMD_SAMPLE, 9'h000, 4'd12);
    queue_cmd(CMD_CLEAR, 9'h1FF, 4'd2);
    drain();

    // Lower the debounce threshold below a count that is already running.
    write_reg(REG_DEBOUNCE_TICKS, 16'd6);
    queue_cmd(CMD_SAMPLE, 9'h001, 4'd0);
    repeat (4) queue_cmd(CMD_TICK, 9'h000, 4'd0);
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 16'd2);
    queue_cmd(CMD_SAMPLE, 9'h001, 4'd0);
    drain();

    for (int p = 0; p < 9; p++) begin
      n = 200;
      if (p == 0) begin
        set_config(16'd0, 16'd0, 16'd0, 1'b0);
      end else if (p == 1) begin
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        n = 60;
      end else begin
        set_config(CNT_W'($urandom_range(0, 4)), CNT_W'($urandom_range(5, 40)),
                   CNT_W'($urandom_range(5, 90)), 1'($urandom_range(0, 1)));
      end
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      queue_sessions(n);
      if (p == 4) hold_off_req = 1'b1;
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bdpc_pkg.sv
rtl/bdpc_button.sv
rtl/button_debounce_press_classifier_unit.sv
rtl/bdpc_checker.sv
tb/sv/testbench.sv
